[sv/sorted_priority_queue_macros.svh]
// assertion macros shared by the sorted priority queue modules
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// condition must hold at every rising clock edge outside reset
`define SPQ_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[sv/spq_pkg.sv]
// types, codes and constants of the sorted priority queue
`default_nettype none
package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int PRIO_W    = 15;
	localparam int REQ_W     = 16;
	localparam int TAG_W     = 16;
	localparam int CMD_W     = 2;
	localparam int ST_W      = 2;
	localparam int IN_W      = 40;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_NOP    = 2'd2;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
	localparam logic [ST_W-1:0] ST_BADPRIO = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

	typedef struct packed {
		logic              occ;
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} ctl_t;

endpackage
`default_nettype wire

[sv/sorted_priority_queue.sv]
// top level of the sorted priority queue: command decode, cell chain, result register
// Usage:
//   s_* carries commands: insert (priority, tag), remove head, or status read.
//   m_* carries one result item per command: status, head entry and count
//   after the command has taken effect.
//   The queue is a chain of DEPTH cells; on an insert each cell compares its
//   priority with the new one and keeps, takes the new entry or takes its
//   upper neighbor's entry; a remove shifts every cell up by one.
//   The result of an accepted command is registered and shows on m_* in the next cycle.
//   Throughput: one command per cycle while s_tready stays high.
//   A result waiting in the output register does not stop a new command
//   as long as the receiver takes it in the same cycle; when m_tready is low
//   with a result pending, s_tready drops and the queue holds its state.
//   Reset clears every occupied flag and the count, so the queue starts empty
//   with no result pending; stored priorities and tags are not cleared.
`default_nettype none
`include "sorted_priority_queue_macros.svh"
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int OUT_W = ((ST_W + 1 + PRIO_W + TAG_W + CNT_W + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// command, priority_req, payload_tag
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// status, head_valid, head_priority, head_tag, entry_count
	output logic [OUT_W-1:0]      m_tdata
);

	localparam int PAD_W = OUT_W - (ST_W + 1 + PRIO_W + TAG_W + CNT_W);

	logic [CMD_W-1:0] command;
	logic [REQ_W-1:0] priority_req;
	logic [TAG_W-1:0] payload_tag;
	logic             accept;
	logic             full;
	logic             empty;
	ctl_t             ctl;
	logic [ST_W-1:0]  status;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic [DEPTH-1:0] occ_vec;

	entry_t cur_w  [DEPTH];
	entry_t nxt_w  [DEPTH];
	entry_t prev_w [DEPTH];
	entry_t next_w [DEPTH];
	logic   keep_w [DEPTH];
	logic   pkeep_w[DEPTH];

	assign command      = s_tdata[CMD_W-1:0];
	assign priority_req = s_tdata[CMD_W +: REQ_W];
	assign payload_tag  = s_tdata[CMD_W + REQ_W +: TAG_W];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	always_comb begin
		status    = ST_OK;
		ctl       = '{ins: 1'b0, rem: 1'b0};
		count_nxt = count_q;
		case (command)
			CMD_INSERT: begin
				if (priority_req[REQ_W-1]) begin
					status = ST_BADPRIO;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					ctl.ins   = accept;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					ctl.rem   = accept;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_w[i]  = '0;
			assign pkeep_w[i] = 1'b1;
		end else begin : g_mid
			assign prev_w[i]  = cur_w[i-1];
			assign pkeep_w[i] = keep_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_w[i] = '0;
		end else begin : g_inner
			assign next_w[i] = cur_w[i+1];
		end
		assign occ_vec[i] = cur_w[i].occ;

		spq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_prio  (priority_req[PRIO_W-1:0]),
			.new_tag   (payload_tag),
			.prev      (prev_w[i]),
			.prev_keep (pkeep_w[i]),
			.next      (next_w[i]),
			.cur       (cur_w[i]),
			.keep      (keep_w[i]),
			.nxt       (nxt_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {
				{PAD_W{1'b0}},
				count_nxt,
				nxt_w[0].occ ? nxt_w[0].tag : {TAG_W{1'b0}},
				nxt_w[0].occ ? nxt_w[0].prio : {PRIO_W{1'b0}},
				nxt_w[0].occ,
				status
			};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`SPQ_ASSERT(a_count_occ, $countones(occ_vec) == int'(count_q), "count disagrees with slots")
	`SPQ_ASSERT(a_count_max, count_q <= CNT_W'(DEPTH), "count above depth")

endmodule
`default_nettype wire

[sv/spq_cell.sv]
// one slot of the sorted list: keeps, takes the new entry or shifts from a neighbor
`default_nettype none
`include "sorted_priority_queue_macros.svh"
module spq_cell
	import spq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctl_t              ctl,
	input  wire logic [PRIO_W-1:0] new_prio,
	input  wire logic [TAG_W-1:0]  new_tag,
	input  wire entry_t            prev,
	input  wire logic              prev_keep,
	input  wire entry_t            next,
	output entry_t                 cur,
	output logic                   keep,
	output entry_t                 nxt
);

	logic              occ_q;
	logic [PRIO_W-1:0] prio_q;
	logic [TAG_W-1:0]  tag_q;

	assign cur  = '{occ: occ_q, prio: prio_q, tag: tag_q};
	assign keep = occ_q && (prio_q >= new_prio);

	always_comb begin
		nxt = cur;
		if (ctl.ins) begin
			if (keep) begin
				nxt = cur;
			end else if (prev_keep) begin
				nxt = '{occ: 1'b1, prio: new_prio, tag: new_tag};
			end else begin
				nxt = prev;
			end
		end else if (ctl.rem) begin
			nxt = next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= nxt.occ;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= nxt.prio;
		tag_q  <= nxt.tag;
	end

	// list stays packed toward the head and sorted
	`SPQ_ASSERT_IMP(a_packed, next.occ, occ_q, "occupied slot behind an empty one")
	`SPQ_ASSERT_IMP(a_sorted, next.occ, prio_q >= next.prio, "slot order broken")

endmodule
`default_nettype wire

[bench/spq_checker.sv]
// checker for the sorted priority queue: watches both channels, predicts and compares result items
module spq_checker
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int OUT_W = 40
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	input  wire logic             s_tready,
	// command, priority_req, payload_tag
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire logic             m_tvalid,
	input  wire logic             m_tready,
	// status, head_valid, head_priority, head_tag, entry_count
	input  wire logic [OUT_W-1:0] m_tdata,
	output int                    mismatches,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic              head_valid;
		logic [PRIO_W-1:0] head_prio;
		logic [TAG_W-1:0]  head_tag;
		logic [CNT_W-1:0]  count;
	} queue_status_t;

	logic [PRIO_W-1:0] slot_prio [DEPTH];
	logic [TAG_W-1:0]  slot_tag [DEPTH];
	int                held_count = 0;
	queue_status_t     expected_status [$];
	int                fail_count = 0;
	int                pending_count = 0;

	assign mismatches = fail_count;
	assign outstanding = pending_count;

	function automatic queue_status_t apply_command(logic [CMD_W-1:0] cmd,
			logic [REQ_W-1:0] req, logic [TAG_W-1:0] tag);
		queue_status_t r;
		int pos;
		int k;
		r.status = ST_OK;
		if (cmd == CMD_INSERT) begin
			if (req[REQ_W-1]) begin
				r.status = ST_BADPRIO;
			end else if (held_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// behind every entry of equal or higher priority
				pos = 0;
				while (pos < held_count && slot_prio[pos] >= req[PRIO_W-1:0])
					pos++;
				for (k = held_count; k > pos; k--) begin
					slot_prio[k] = slot_prio[k-1];
					slot_tag[k] = slot_tag[k-1];
				end
				slot_prio[pos] = req[PRIO_W-1:0];
				slot_tag[pos] = tag;
				held_count++;
			end
		end else if (cmd == CMD_REMOVE) begin
			if (held_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				for (k = 0; k + 1 < held_count; k++) begin
					slot_prio[k] = slot_prio[k+1];
					slot_tag[k] = slot_tag[k+1];
				end
				held_count--;
			end
		end
		r.head_valid = held_count > 0;
		r.head_prio = (held_count > 0) ? slot_prio[0] : '0;
		r.head_tag = (held_count > 0) ? slot_tag[0] : '0;
		r.count = held_count[CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin : watch
		queue_status_t got;
		queue_status_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[ST_W-1:0];
				got.head_valid = m_tdata[ST_W];
				got.head_prio = m_tdata[ST_W+1 +: PRIO_W];
				got.head_tag = m_tdata[ST_W+1+PRIO_W +: TAG_W];
				got.count = m_tdata[ST_W+1+PRIO_W+TAG_W +: CNT_W];
				if (expected_status.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected result item %h", m_tdata);
				end else begin
					want = expected_status.pop_front();
					if (got.status !== want.status || got.head_valid !== want.head_valid ||
							got.head_prio !== want.head_prio ||
							got.head_tag !== want.head_tag || got.count !== want.count) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$write("mismatch: expected st %0d vld %0d prio %0d tag %h cnt %0d",
								want.status, want.head_valid, want.head_prio, want.head_tag,
								want.count);
							$display(", got st %0d vld %0d prio %0d tag %h cnt %0d",
								got.status, got.head_valid, got.head_prio,
								got.head_tag, got.count);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_status.push_back(apply_command(s_tdata[CMD_W-1:0],
					s_tdata[CMD_W +: REQ_W], s_tdata[CMD_W+REQ_W +: TAG_W]));
			pending_count = expected_status.size();
		end
	end

endmodule

[bench/tb.sv]
// top of the sorted priority queue bench: clock, reset, command stimulus and verdict
module tb
	import spq_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CNT_W = $clog2(DEPTH_DEF + 1);
	localparam int OUT_W = ((ST_W + 1 + PRIO_W + TAG_W + CNT_W + 7) / 8) * 8;
	localparam int PAD_W = IN_W - CMD_W - REQ_W - TAG_W;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 1550;
	localparam int HOLD_CYCLES = 80;
	localparam int HOLD_ITEMS = 30;
	localparam int HOLD_AT = 400;
	localparam int DRAIN_AT = 800;
	localparam int QUIET_TAIL = 150;
	localparam int CYCLE_LIMIT = 400000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	// command, priority_req, payload_tag
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	// status, head_valid, head_priority, head_tag, entry_count
	logic [OUT_W-1:0] m_tdata;
	int               mismatches;
	int               outstanding;
	int               cycle_count = 0;
	bit               hold_go = 1'b0;
	bit               rx_free = 1'b0;

	sorted_priority_queue #(.DEPTH(DEPTH_DEF)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	spq_checker #(.DEPTH(DEPTH_DEF), .OUT_W(OUT_W)) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic put_item(logic [CMD_W-1:0] cmd, logic [REQ_W-1:0] req, logic [TAG_W-1:0] tag);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {{PAD_W{1'b0}}, tag, req, cmd};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic idle(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
	endtask

	task automatic wait_drained();
		idle(1);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic put_random(int ins_weight, int rem_weight, bit gaps);
		int roll;
		logic [CMD_W-1:0] cmd;
		logic [REQ_W-1:0] req;
		roll = $urandom_range(0, 99);
		if (roll < ins_weight)
			cmd = CMD_INSERT;
		else if (roll < ins_weight + rem_weight)
			cmd = CMD_REMOVE;
		else if (roll % 2 == 0)
			cmd = CMD_NOP;
		else
			cmd = CMD_SPARE;
		case ($urandom_range(0, 9))
			0: req = {1'b1, 15'($urandom)};
			1: req = '0;
			2: req = 16'h7FFF;
			3, 4, 5, 6: req = 16'($urandom_range(0, 7));
			default: req = 16'($urandom_range(0, 32767));
		endcase
		if (gaps && $urandom_range(0, 5) == 0)
			idle($urandom_range(1, 15));
		put_item(cmd, req, 16'($urandom));
	endtask

	// receiver: random stall bursts, one long hold on request, none at the end
	initial begin : receiver
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				m_tready <= 1'b0;
				for (n = 1; n < HOLD_CYCLES; n++) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end else if (!rx_free && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 15);
				m_tready <= 1'b0;
				repeat (n - 1) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int sent;
		int phase_left;
		int ins_w;
		int rem_w;
		int hold_left;
		int k;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// empty queue: status reads, spare command, remove on empty
		put_item(CMD_NOP, 16'h0000, 16'h0000);
		put_item(CMD_SPARE, 16'hFFFF, 16'hFFFF);
		put_item(CMD_REMOVE, 16'h1234, 16'h5678);
		// negative priorities
		put_item(CMD_INSERT, 16'h8000, 16'hFFFF);
		put_item(CMD_INSERT, 16'hFFFF, 16'h0001);
		// extremes and equal priorities leaving in arrival order
		put_item(CMD_INSERT, 16'h0000, 16'h0000);
		put_item(CMD_INSERT, 16'h7FFF, 16'hFFFF);
		put_item(CMD_INSERT, 16'h7FFF, 16'h0001);
		put_item(CMD_INSERT, 16'h0000, 16'h0002);
		put_item(CMD_INSERT, 16'h4000, 16'hAAAA);
		put_item(CMD_REMOVE, 16'h0000, 16'h0000);
		put_item(CMD_SPARE, 16'h5555, 16'h5555);
		// fill to the limit, then full and negative-while-full
		for (k = 0; k < 12; k++)
			put_item(CMD_INSERT, 16'(k % 3), 16'(16'h0100 + k));
		put_item(CMD_INSERT, 16'h7FFF, 16'hBEEF);
		put_item(CMD_INSERT, 16'h8001, 16'hCAFE);

		sent = 0;
		phase_left = 0;
		hold_left = 0;
		ins_w = 45;
		rem_w = 45;
		while (sent < RANDOM_ITEMS) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 120);
				case ($urandom_range(0, 2))
					0: begin ins_w = 70; rem_w = 20; end
					1: begin ins_w = 20; rem_w = 70; end
					default: begin ins_w = 45; rem_w = 45; end
				endcase
			end
			if (sent == HOLD_AT) begin
				hold_go = 1'b1;
				hold_left = HOLD_ITEMS;
			end
			if (sent == DRAIN_AT)
				wait_drained();
			if (sent == RANDOM_ITEMS - QUIET_TAIL)
				rx_free = 1'b1;
			put_random(ins_w, rem_w, hold_left == 0 && !rx_free);
			if (hold_left > 0)
				hold_left--;
			phase_left--;
			sent++;
		end

		wait_drained();
		repeat (4) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
